### src/c2d_pkg.sv
// Package for the conv2d stride/padding core: commands, register indexes and
// controller state and command types. No dependencies.
`timescale 1ns / 1ps
package c2d_pkg;

   typedef enum logic [1:0] {
      CMD_PIXEL  = 2'd0,
      CMD_WEIGHT = 2'd1,
      CMD_BIAS   = 2'd2,
      CMD_CONV   = 2'd3
   } cmd_type;

   localparam logic [2:0] REG_IN_CH   = 3'd0;
   localparam logic [2:0] REG_OUT_CH  = 3'd1;
   localparam logic [2:0] REG_IN_H    = 3'd2;
   localparam logic [2:0] REG_IN_W    = 3'd3;
   localparam logic [2:0] REG_KERNEL  = 3'd4;
   localparam logic [2:0] REG_STEP    = 3'd5;
   localparam logic [2:0] REG_PAD     = 3'd6;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_RUN,
      ST_DRAIN,
      ST_DONE
   } state_type;

   // Controller to datapath.
   typedef struct packed {
      logic latch;    // capture the accepted item
      logic do_write; // store write for a write item
      logic start;    // load the bias into the accumulator and clear the tap counters
      logic advance;  // issue one tap
      logic finish;   // round and load the result register
   } ctl_type;

   // Datapath to controller.
   typedef struct packed {
      logic is_conv;
      logic bad_pos;
      logic last_tap;
      logic pipe_empty;
   } sts_type;

endpackage

### src/conv2d_stride_padding_core.sv
// Conv2d core: a compute word does one multiply-accumulate per tap over
// in_channels*kernel_size^2 taps, paced by the single read port of each store;
// taps that fall in the padding add nothing. A finished result waits while an
// earlier result is stalled. Reset is synchronous, active high; configuration
// registers return to their defaults and biases clear. Pixel and weight stores
// are not cleared.
`timescale 1ns / 1ps
module conv2d_stride_padding_core #(
   parameter int MAX_IN_CH  = 16,
   parameter int MAX_OUT_CH = 16,
   parameter int MAX_DIM    = 64,
   parameter int MAX_KERNEL = 7
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write,
   input  logic [2:0]         csr_index,
   input  logic [6:0]         csr_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_cmd,
   input  logic [3:0]         req_out_chan,
   input  logic [3:0]         req_in_chan,
   input  logic [5:0]         req_row,
   input  logic [5:0]         req_col,
   input  logic [2:0]         req_tap_row,
   input  logic [2:0]         req_tap_col,
   input  logic signed [15:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_sum,
   output logic               rsp_saturated,
   output logic               rsp_bad_position
);

   c2d_pkg::ctl_type ctl;
   c2d_pkg::sts_type sts;

   c2d_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .sts(sts), .ctl(ctl)
   );

   c2d_datapath #(
      .MAX_IN_CH(MAX_IN_CH), .MAX_OUT_CH(MAX_OUT_CH),
      .MAX_DIM(MAX_DIM), .MAX_KERNEL(MAX_KERNEL)
   ) u_dp (
      .clock(clock), .reset(reset), .csr_write(csr_write), .csr_index(csr_index),
      .csr_data(csr_data), .req_cmd(req_cmd), .req_out_chan(req_out_chan),
      .req_in_chan(req_in_chan), .req_row(req_row), .req_col(req_col),
      .req_tap_row(req_tap_row), .req_tap_col(req_tap_col), .req_value(req_value),
      .ctl(ctl), .sts(sts), .rsp_sum(rsp_sum), .rsp_saturated(rsp_saturated),
      .rsp_bad_position(rsp_bad_position)
   );

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      ctl.advance |-> req_stall) else $error("word accepted during compute");
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_bad_position) |-> (rsp_sum == 16'sd0 && !rsp_saturated))
      else $error("bad position result not zero");
   a_finish_once: assert property (@(posedge clock) disable iff (reset)
      ctl.finish |=> !ctl.finish) else $error("result loaded twice");

endmodule

### src/c2d_ctrl.sv
// Controller state machine for the conv2d core.
// Depends on c2d_pkg.
`timescale 1ns / 1ps
module c2d_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  c2d_pkg::sts_type  sts,
   output c2d_pkg::ctl_type  ctl
);

   c2d_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         c2d_pkg::ST_IDLE: begin
            if (req_valid) state_in = c2d_pkg::ST_CHECK;
         end
         c2d_pkg::ST_CHECK: begin
            if (!sts.is_conv) state_in = c2d_pkg::ST_IDLE;
            else if (sts.bad_pos) state_in = c2d_pkg::ST_DONE;
            else state_in = c2d_pkg::ST_RUN;
         end
         c2d_pkg::ST_RUN: begin
            if (sts.last_tap) state_in = c2d_pkg::ST_DRAIN;
         end
         c2d_pkg::ST_DRAIN: begin
            if (sts.pipe_empty) state_in = c2d_pkg::ST_DONE;
         end
         c2d_pkg::ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) state_in = c2d_pkg::ST_IDLE;
         end
         default: state_in = c2d_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      ctl = '0;
      req_stall = (state_ff != c2d_pkg::ST_IDLE);
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         c2d_pkg::ST_IDLE: ctl.latch = req_valid;
         c2d_pkg::ST_CHECK: begin
            ctl.do_write = !sts.is_conv;
            ctl.start = sts.is_conv && !sts.bad_pos;
         end
         c2d_pkg::ST_RUN: ctl.advance = 1'b1;
         c2d_pkg::ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               ctl.finish = 1'b1;
               rsp_valid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= c2d_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

### src/c2d_datapath.sv
// Datapath of the conv2d core: configuration registers, stores, tap counters,
// multiply-accumulate pipeline and result register. Depends on c2d_pkg.
`timescale 1ns / 1ps
module c2d_datapath #(
   parameter int MAX_IN_CH  = 16,
   parameter int MAX_OUT_CH = 16,
   parameter int MAX_DIM    = 64,
   parameter int MAX_KERNEL = 7
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write,
   input  logic [2:0]         csr_index,
   input  logic [6:0]         csr_data,
   input  logic [1:0]         req_cmd,
   input  logic [3:0]         req_out_chan,
   input  logic [3:0]         req_in_chan,
   input  logic [5:0]         req_row,
   input  logic [5:0]         req_col,
   input  logic [2:0]         req_tap_row,
   input  logic [2:0]         req_tap_col,
   input  logic signed [15:0] req_value,
   input  c2d_pkg::ctl_type   ctl,
   output c2d_pkg::sts_type   sts,
   output logic signed [15:0] rsp_sum,
   output logic               rsp_saturated,
   output logic               rsp_bad_position
);

   localparam int IcW = (MAX_IN_CH > 1) ? $clog2(MAX_IN_CH) : 1;
   localparam int OcW = (MAX_OUT_CH > 1) ? $clog2(MAX_OUT_CH) : 1;
   localparam int DW  = $clog2(MAX_DIM);
   localparam int KW  = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
   localparam int PixDepth = MAX_IN_CH * MAX_DIM * MAX_DIM;
   localparam int WgtDepth = MAX_OUT_CH * MAX_IN_CH * MAX_KERNEL * MAX_KERNEL;
   localparam int PaW = $clog2(PixDepth);
   localparam int WaW = (WgtDepth > 1) ? $clog2(WgtDepth) : 1;
   // Signed coordinates wide enough for row*stride + tap.
   localparam int CW = DW + 5;

   logic [4:0] in_ch_ff, out_ch_ff;
   logic [6:0] in_h_ff, in_w_ff;
   logic [2:0] ksz_ff, step_ff;
   logic [1:0] pad_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_ch_ff <= 5'd1; out_ch_ff <= 5'd1; in_h_ff <= 7'd64; in_w_ff <= 7'd64;
         ksz_ff <= 3'd3; step_ff <= 3'd1; pad_ff <= 2'd1;
      end else if (csr_write) begin
         case (csr_index)
            c2d_pkg::REG_IN_CH:  in_ch_ff  <= csr_data[4:0];
            c2d_pkg::REG_OUT_CH: out_ch_ff <= csr_data[4:0];
            c2d_pkg::REG_IN_H:   in_h_ff   <= csr_data;
            c2d_pkg::REG_IN_W:   in_w_ff   <= csr_data;
            c2d_pkg::REG_KERNEL: ksz_ff    <= csr_data[2:0];
            c2d_pkg::REG_STEP:   step_ff   <= csr_data[2:0];
            c2d_pkg::REG_PAD:    pad_ff    <= csr_data[1:0];
            default: ;
         endcase
      end
   end

   // Clamped configuration, 12 bits covers all sums here.
   logic [11:0] nic, noc, h, w, k, s, p;
   always_comb begin
      nic = (in_ch_ff == 5'd0) ? 12'd1 :
            (12'(in_ch_ff) > 12'(MAX_IN_CH)) ? 12'(MAX_IN_CH) : 12'(in_ch_ff);
      noc = (out_ch_ff == 5'd0) ? 12'd1 :
            (12'(out_ch_ff) > 12'(MAX_OUT_CH)) ? 12'(MAX_OUT_CH) : 12'(out_ch_ff);
      h = (in_h_ff == 7'd0) ? 12'd1 :
          (12'(in_h_ff) > 12'(MAX_DIM)) ? 12'(MAX_DIM) : 12'(in_h_ff);
      w = (in_w_ff == 7'd0) ? 12'd1 :
          (12'(in_w_ff) > 12'(MAX_DIM)) ? 12'(MAX_DIM) : 12'(in_w_ff);
      k = (ksz_ff == 3'd0) ? 12'd1 :
          (12'(ksz_ff) > 12'(MAX_KERNEL)) ? 12'(MAX_KERNEL) : 12'(ksz_ff);
      s = (step_ff == 3'd0) ? 12'd1 : (step_ff > 3'd4) ? 12'd4 : 12'(step_ff);
      p = 12'(pad_ff);
   end

   // Captured item.
   logic [1:0]         cmd_ff;
   logic [3:0]         oc_ff, ic_ff;
   logic [5:0]         row_ff, col_ff;
   logic [2:0]         tr_ff, tc_ff;
   logic signed [15:0] val_ff;

   always_ff @(posedge clock) begin
      if (ctl.latch) begin
         cmd_ff <= req_cmd; oc_ff <= req_out_chan; ic_ff <= req_in_chan;
         row_ff <= req_row; col_ff <= req_col; tr_ff <= req_tap_row;
         tc_ff <= req_tap_col; val_ff <= req_value;
      end
   end

   // Bad position test: row >= oh is row*s + k > h + 2p (with oh = 0 covered).
   logic [11:0] span_h, span_w, need_r, need_c;
   logic        bad;
   always_comb begin
      span_h = h + (p << 1);
      span_w = w + (p << 1);
      need_r = 12'(row_ff) * s[2:0] + k;
      need_c = 12'(col_ff) * s[2:0] + k;
      bad = (12'(oc_ff) >= noc) || (need_r > span_h) || (need_c > span_w);
   end

   // Stores.
   logic signed [15:0] pix_mem [PixDepth];
   logic signed [15:0] wgt_mem [WgtDepth];
   logic signed [15:0] bias_ff [MAX_OUT_CH];

   logic wr_pix_ok, wr_wgt_ok, wr_bias_ok;
   logic [PaW-1:0] wr_pix_addr;
   logic [WaW-1:0] wr_wgt_addr;
   always_comb begin
      wr_pix_ok = (32'(ic_ff) < 32'(MAX_IN_CH)) && (32'(row_ff) < 32'(MAX_DIM))
                  && (32'(col_ff) < 32'(MAX_DIM));
      wr_wgt_ok = (32'(oc_ff) < 32'(MAX_OUT_CH)) && (32'(ic_ff) < 32'(MAX_IN_CH))
                  && (32'(tr_ff) < 32'(MAX_KERNEL)) && (32'(tc_ff) < 32'(MAX_KERNEL));
      wr_bias_ok = 32'(oc_ff) < 32'(MAX_OUT_CH);
      wr_pix_addr = PaW'((32'(ic_ff) * MAX_DIM + 32'(row_ff)) * MAX_DIM + 32'(col_ff));
      wr_wgt_addr = WaW'(((32'(oc_ff) * MAX_IN_CH + 32'(ic_ff)) * MAX_KERNEL
                          + 32'(tr_ff)) * MAX_KERNEL + 32'(tc_ff));
   end

   // Tap counters: channel, kernel row, kernel column.
   logic [IcW-1:0] c_ff, c_in;
   logic [KW-1:0]  ky_ff, ky_in, kx_ff, kx_in;
   logic signed [CW-1:0] iy, ix;
   logic           tap_ok, last;
   logic [PaW-1:0] rd_pix_addr;
   logic [WaW-1:0] rd_wgt_addr;

   always_comb begin
      iy = CW'(row_ff) * $signed({1'b0, s[2:0]}) + CW'(ky_ff) - CW'(p);
      ix = CW'(col_ff) * $signed({1'b0, s[2:0]}) + CW'(kx_ff) - CW'(p);
      tap_ok = (iy >= 0) && (iy < $signed(CW'(h))) && (ix >= 0)
               && (ix < $signed(CW'(w)));
      rd_pix_addr = PaW'((32'(c_ff) * MAX_DIM + 32'(iy)) * MAX_DIM + 32'(ix));
      rd_wgt_addr = WaW'(((32'(oc_ff) * MAX_IN_CH + 32'(c_ff)) * MAX_KERNEL
                          + 32'(ky_ff)) * MAX_KERNEL + 32'(kx_ff));
      last = (12'(kx_ff) == k - 12'd1) && (12'(ky_ff) == k - 12'd1)
             && (12'(c_ff) == nic - 12'd1);
      c_in = c_ff; ky_in = ky_ff; kx_in = kx_ff;
      if (ctl.start) begin
         c_in = '0; ky_in = '0; kx_in = '0;
      end else if (ctl.advance) begin
         if (12'(kx_ff) != k - 12'd1) kx_in = kx_ff + KW'(1);
         else begin
            kx_in = '0;
            if (12'(ky_ff) != k - 12'd1) ky_in = ky_ff + KW'(1);
            else begin
               ky_in = '0;
               c_in = c_ff + IcW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      c_ff <= c_in; ky_ff <= ky_in; kx_ff <= kx_in;
   end

   // Store access: one write port, one registered read port each.
   logic signed [15:0] pix_rd_ff, wgt_rd_ff;
   always_ff @(posedge clock) begin
      if (ctl.do_write && cmd_ff == c2d_pkg::CMD_PIXEL && wr_pix_ok)
         pix_mem[wr_pix_addr] <= val_ff;
      pix_rd_ff <= pix_mem[rd_pix_addr];
   end
   always_ff @(posedge clock) begin
      if (ctl.do_write && cmd_ff == c2d_pkg::CMD_WEIGHT && wr_wgt_ok)
         wgt_mem[wr_wgt_addr] <= val_ff;
      wgt_rd_ff <= wgt_mem[rd_wgt_addr];
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_OUT_CH; i++) bias_ff[i] <= '0;
      end else if (ctl.do_write && cmd_ff == c2d_pkg::CMD_BIAS && wr_bias_ok) begin
         bias_ff[OcW'(oc_ff)] <= val_ff;
      end
   end

   // MAC pipeline: read, multiply, accumulate.
   logic               v1_ff, v2_ff;
   logic signed [31:0] prod_ff;
   logic signed [47:0] acc_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0; v2_ff <= 1'b0;
      end else begin
         v1_ff <= ctl.advance && tap_ok;
         v2_ff <= v1_ff;
      end
   end
   always_ff @(posedge clock) begin
      prod_ff <= pix_rd_ff * wgt_rd_ff;
      if (ctl.start) acc_ff <= 48'(bias_ff[OcW'(oc_ff)]) <<< 11;
      else if (v2_ff) acc_ff <= acc_ff + 48'(prod_ff);
   end

   // Round half up and saturate.
   logic signed [47:0] rnd;
   logic signed [36:0] q;
   logic signed [15:0] sum_in;
   logic               sat_in;
   always_comb begin
      rnd = acc_ff + 48'sd1024;
      q = rnd[47:11];
      sat_in = 1'b1;
      if (q > 37'sd32767) sum_in = 16'sh7fff;
      else if (q < -37'sd32768) sum_in = 16'sh8000;
      else begin
         sum_in = q[15:0];
         sat_in = 1'b0;
      end
   end

   logic bad_q_ff;
   always_ff @(posedge clock) begin
      if (ctl.start) bad_q_ff <= 1'b0;
      else if (ctl.latch) bad_q_ff <= 1'b1;
   end

   logic signed [15:0] sum_ff;
   logic               sat_ff, badp_ff;
   always_ff @(posedge clock) begin
      if (ctl.finish) begin
         sum_ff <= bad_q_ff ? 16'sd0 : sum_in;
         sat_ff <= bad_q_ff ? 1'b0 : sat_in;
         badp_ff <= bad_q_ff;
      end
   end

   assign sts.is_conv    = (cmd_ff == c2d_pkg::CMD_CONV);
   assign sts.bad_pos    = bad;
   assign sts.last_tap   = last;
   assign sts.pipe_empty = !v1_ff && !v2_ff;

   assign rsp_sum          = sum_ff;
   assign rsp_saturated    = sat_ff;
   assign rsp_bad_position = badp_ff;

endmodule
